>>> sv/uarb_pkg.sv
// shared constants, command codes and ring pointer helpers for the uart ring buffers
package uarb_pkg;

	// ring size and pointer widths
	localparam int DEPTH = 256;
	localparam int PTR_W = $clog2(DEPTH);

	localparam logic [PTR_W-1:0] PTR_LAST    = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W-1:0] PTR_LAST_M1 = PTR_W'(DEPTH - 2);
	localparam logic [PTR_W:0]   DEPTH_X     = (PTR_W + 1)'(DEPTH);

	// command codes
	localparam logic [1:0] CMD_LINE_RX  = 2'd0;
	localparam logic [1:0] CMD_TX_READY = 2'd1;
	localparam logic [1:0] CMD_SW_READ  = 2'd2;
	localparam logic [1:0] CMD_SW_WRITE = 2'd3;

	// characters
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// pointer step with wrap at the ring end
	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	// bytes waiting between head and tail
	function automatic logic [PTR_W-1:0] ring_count(input logic [PTR_W-1:0] head,
		input logic [PTR_W-1:0] tail);
		logic [PTR_W:0] sum;
		if (tail >= head) begin
			sum = {1'b0, tail} - {1'b0, head};
		end else begin
			sum = {1'b0, tail} + DEPTH_X - {1'b0, head};
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

>>> sv/uart_async_ring_buffers.sv
// receive and transmit ring buffers between a serial line and software
// results: a push, a write of one byte, an empty pop or a dropped item is registered
// in the cycle after it is accepted; a pop with data first waits in a read state for the
// registered ring memory read, and a line feed write puts CR, then LF in ST_WR_LF, as each
// ring has a single write port. a new item is taken only while idle with the result free.
// reset: pointers and the transmit request clear at once; ring memories are never cleared.
module uart_async_ring_buffers (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       line_valid,
	output logic [7:0] line_byte,
	output logic       read_valid,
	output logic [7:0] read_byte,
	output logic       tx_irq_on,
	output logic       overflow,
	output logic [7:0] rx_level,
	output logic [7:0] tx_level
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ_RX,
		ST_READ_TX,
		ST_WR_LF
	} state_t;

	state_t state_q, state_d;

	// ring pointers and transmit request
	logic [uarb_pkg::PTR_W-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
	logic [uarb_pkg::PTR_W-1:0] rx_head_d, rx_tail_d, tx_head_d, tx_tail_d;
	logic                       irq_q, irq_d;

	// result register
	logic       out_valid_q;
	logic       line_valid_q, read_valid_q, overflow_q;
	logic [7:0] line_byte_q, read_byte_q, rx_level_q, tx_level_q;

	// memory ports
	logic [7:0]                 rx_mem [uarb_pkg::DEPTH];
	logic [7:0]                 tx_mem [uarb_pkg::DEPTH];
	logic                       rx_we, tx_we, rx_re, tx_re;
	logic [7:0]                 tx_wd;
	logic [7:0]                 rx_rd_q, tx_rd_q;

	// next-item logic
	logic                       accept;
	logic                       load;
	logic                       lv_d, rv_d, ovf_d;
	logic [7:0]                 lb_d, rb_d;
	logic [uarb_pkg::PTR_W-1:0] rx_cnt, tx_cnt;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	assign rx_cnt = uarb_pkg::ring_count(rx_head_q, rx_tail_q);
	assign tx_cnt = uarb_pkg::ring_count(tx_head_q, tx_tail_q);

	// command decode and pointer updates
	always_comb begin
		state_d   = state_q;
		rx_head_d = rx_head_q;
		rx_tail_d = rx_tail_q;
		tx_head_d = tx_head_q;
		tx_tail_d = tx_tail_q;
		irq_d     = irq_q;
		rx_we     = 1'b0;
		tx_we     = 1'b0;
		rx_re     = 1'b0;
		tx_re     = 1'b0;
		tx_wd     = data_byte;
		load      = 1'b0;
		lv_d      = 1'b0;
		lb_d      = '0;
		rv_d      = 1'b0;
		rb_d      = '0;
		ovf_d     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						uarb_pkg::CMD_LINE_RX: begin
							load = 1'b1;
							if (rx_cnt == uarb_pkg::PTR_LAST) begin
								ovf_d = 1'b1;
							end else begin
								rx_we     = 1'b1;
								rx_tail_d = uarb_pkg::ring_next(rx_tail_q);
							end
						end
						uarb_pkg::CMD_TX_READY: begin
							if (tx_head_q == tx_tail_q) begin
								irq_d = 1'b0;
								load  = 1'b1;
							end else begin
								tx_re     = 1'b1;
								tx_head_d = uarb_pkg::ring_next(tx_head_q);
								state_d   = ST_READ_TX;
							end
						end
						uarb_pkg::CMD_SW_READ: begin
							if (rx_head_q == rx_tail_q) begin
								load = 1'b1;
							end else begin
								rx_re     = 1'b1;
								rx_head_d = uarb_pkg::ring_next(rx_head_q);
								state_d   = ST_READ_RX;
							end
						end
						default: begin
							irq_d = 1'b1;
							if (data_byte == uarb_pkg::CH_LF) begin
								if (tx_cnt < uarb_pkg::PTR_LAST_M1) begin
									tx_we     = 1'b1;
									tx_wd     = uarb_pkg::CH_CR;
									tx_tail_d = uarb_pkg::ring_next(tx_tail_q);
									state_d   = ST_WR_LF;
								end else begin
									ovf_d = 1'b1;
									load  = 1'b1;
								end
							end else if (tx_cnt == uarb_pkg::PTR_LAST) begin
								ovf_d = 1'b1;
								load  = 1'b1;
							end else begin
								tx_we     = 1'b1;
								tx_tail_d = uarb_pkg::ring_next(tx_tail_q);
								load      = 1'b1;
							end
						end
					endcase
				end
			end
			ST_READ_TX: begin
				lv_d    = 1'b1;
				lb_d    = tx_rd_q;
				load    = 1'b1;
				state_d = ST_IDLE;
			end
			ST_READ_RX: begin
				rv_d    = 1'b1;
				rb_d    = (rx_rd_q == uarb_pkg::CH_CR) ? uarb_pkg::CH_LF : rx_rd_q;
				load    = 1'b1;
				state_d = ST_IDLE;
			end
			ST_WR_LF: begin
				tx_we     = 1'b1;
				tx_wd     = uarb_pkg::CH_LF;
				tx_tail_d = uarb_pkg::ring_next(tx_tail_q);
				load      = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, pointers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rx_head_q    <= '0;
			rx_tail_q    <= '0;
			tx_head_q    <= '0;
			tx_tail_q    <= '0;
			irq_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			line_valid_q <= 1'b0;
			line_byte_q  <= '0;
			read_valid_q <= 1'b0;
			read_byte_q  <= '0;
			overflow_q   <= 1'b0;
			rx_level_q   <= '0;
			tx_level_q   <= '0;
		end else begin
			state_q   <= state_d;
			rx_head_q <= rx_head_d;
			rx_tail_q <= rx_tail_d;
			tx_head_q <= tx_head_d;
			tx_tail_q <= tx_tail_d;
			irq_q     <= irq_d;
			if (load) begin
				out_valid_q  <= 1'b1;
				line_valid_q <= lv_d;
				line_byte_q  <= lb_d;
				read_valid_q <= rv_d;
				read_byte_q  <= rb_d;
				overflow_q   <= ovf_d;
				rx_level_q   <= 8'(uarb_pkg::ring_count(rx_head_d, rx_tail_d));
				tx_level_q   <= 8'(uarb_pkg::ring_count(tx_head_d, tx_tail_d));
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// receive ring memory
	always_ff @(posedge clk) begin
		if (rx_we) begin
			rx_mem[rx_tail_q] <= data_byte;
		end
		if (rx_re) begin
			rx_rd_q <= rx_mem[rx_head_q];
		end
	end

	// transmit ring memory
	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_tail_q] <= tx_wd;
		end
		if (tx_re) begin
			tx_rd_q <= tx_mem[tx_head_q];
		end
	end

	assign out_valid  = out_valid_q;
	assign line_valid = line_valid_q;
	assign line_byte  = line_byte_q;
	assign read_valid = read_valid_q;
	assign read_byte  = read_byte_q;
	assign tx_irq_on  = irq_q;
	assign overflow   = overflow_q;
	assign rx_level   = rx_level_q;
	assign tx_level   = tx_level_q;

`ifndef SYNTH
	// a pop with data enters the read state, with no result yet, while the memory read runs
	a_rx_pop_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == uarb_pkg::CMD_SW_READ && rx_head_q != rx_tail_q)
		|=> (state_q == ST_READ_RX && !out_valid_q))
		else $error("rx pop did not enter read wait");

	// the second half of a line feed pair is written in the next cycle only
	a_lf_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR_LF) |=> (state_q == ST_IDLE && out_valid_q))
		else $error("line feed write did not finish");

	// no result is held while an item is still in progress
	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !out_valid_q)
		else $error("result pending during work on an item");

	// a result never carries both a sent byte and a read byte
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(line_valid_q && read_valid_q))
		else $error("line and read result both valid");

	// the transmit request goes up on every software write
	a_irq_set: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == uarb_pkg::CMD_SW_WRITE) |=> irq_q)
		else $error("transmit request not set by write");
`endif

endmodule
